[sv/assert_macros.svh]
// Assertion macros shared by the rasterizer RTL modules.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

[sv/rlr_pkg.sv]
// Package for the reflecting line rasterizer: field widths, stream layouts,
// controller states and the command and status types. It depends on nothing.
`default_nettype none

package rlr_pkg;

    localparam int COORD_IN_W  = 4;
    localparam int DIR_W       = 7;
    localparam int COUNT_W     = 5;
    localparam int MAG_W       = 6;
    localparam int ERR_W       = 9;
    localparam int MAX_POINTS  = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    localparam int START_X_LSB = 0;
    localparam int START_Y_LSB = START_X_LSB + COORD_IN_W;
    localparam int DIR_X_LSB   = START_Y_LSB + COORD_IN_W;
    localparam int DIR_Y_LSB   = DIR_X_LSB + DIR_W;
    localparam int COUNT_LSB   = DIR_Y_LSB + DIR_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic count_nonzero;
        logic last;
    } t_status;

endpackage

`default_nettype wire

[sv/reflecting_line_rasterizer.sv]
// Top level of the reflecting line rasterizer: stream ports, controller and datapath.
// It depends on rlr_pkg, rlr_ctrl and rlr_datapath.
`default_nettype none

// One input item gives a start cell, a direction vector and a point count; the block
// then emits that many points of the Bresenham line from the start cell, reflecting
// off the grid walls, with tlast on the final point. Points leave one per cycle while
// the output is ready, since the datapath makes one error and cell update per point,
// and the next item is taken in the cycle after the last point; an item with a zero
// count emits nothing. Counts above 16 are treated as 16, direction -64 as -63, and
// start coordinates beyond the grid are clamped to its far edge.
module reflecting_line_rasterizer #(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields from bit 0: start_x[3:0], start_y[7:4], dir_x[14:8], dir_y[21:15],
    // point_count[26:22], zero padding[31:27].
    input  wire logic [rlr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // Fields from bit 0: point_x[3:0], point_y[7:4].
    output logic [rlr_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import rlr_pkg::*;

    t_cmd    cmd;
    t_status status;

    rlr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    rlr_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    assign o_m_axis_tlast = status.last;

endmodule

`default_nettype wire

[sv/rlr_ctrl.sv]
// Controller of the reflecting line rasterizer: the run state machine and the
// stream handshakes. It depends on rlr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rlr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    input  wire rlr_pkg::t_status i_status,
    output rlr_pkg::t_cmd        o_cmd
);
    import rlr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.count_nonzero) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEVER(a_one_item_at_a_time, o_m_axis_tvalid && o_s_axis_tready, "input taken during a run")
    `ASSERT_CLK(a_last_ends_run, (o_m_axis_tvalid && i_m_axis_tready && i_status.last) |=> o_s_axis_tready, "run did not end after last point")
    `ASSERT_NEVER(a_no_load_and_advance, o_cmd.load && o_cmd.advance, "load and advance together")

endmodule

`default_nettype wire

[sv/rlr_datapath.sv]
// Datapath of the reflecting line rasterizer: input decode, current cell, step
// signs, Bresenham error and point counter. It depends on rlr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rlr_datapath #(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [rlr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire rlr_pkg::t_cmd                   i_cmd,
    output rlr_pkg::t_status                     o_status,
    output logic [rlr_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import rlr_pkg::*;

    localparam int CW = $clog2(GRID_SIZE);
    localparam logic [CW:0] GRID_LIM = (CW + 1)'(GRID_SIZE);
    localparam logic [CW-1:0] GRID_MAX = CW'(GRID_SIZE - 1);
    localparam logic [CW+COORD_IN_W:0] GRID_CMP = (CW + COORD_IN_W + 1)'(GRID_SIZE);

    logic [CW-1:0]     r_cur_x, r_cur_y;
    logic [CW-1:0]     n_cur_x, n_cur_y;
    logic              r_neg_x, r_neg_y;
    logic              n_neg_x, n_neg_y;
    logic [MAG_W-1:0]  r_mag_x, r_mag_y;
    logic [MAG_W-1:0]  n_mag_x, n_mag_y;
    logic [ERR_W-1:0]  r_err, n_err;
    logic [COUNT_W-1:0] r_left, n_left;

    logic [COORD_IN_W-1:0]    in_start_x, in_start_y;
    logic [DIR_W-1:0]         in_dir_x, in_dir_y;
    logic [COUNT_W-1:0]       in_count;
    logic [CW+COORD_IN_W:0]   sx_ext, sy_ext;
    logic [CW-1:0]            start_x_cl, start_y_cl;
    logic [DIR_W-1:0]         dir_x_sat, dir_y_sat, abs_x, abs_y;
    logic [COUNT_W-1:0]       count_sat;
    logic signed [ERR_W:0]    e2;
    logic signed [ERR_W:0]    neg_mag_x_ext, mag_y_ext;
    logic                     step_y, step_x;
    logic [CW:0]              y_next, x_next;
    logic [CW+3:0]            px_ext, py_ext;

    function automatic logic [CW:0] axis_step(input logic [CW-1:0] pos, input logic neg);
        logic        nneg;
        logic [CW:0] pos_ext;
        begin
            pos_ext = {1'b0, pos};
            nneg    = neg;
            if (neg) begin
                if (pos == '0) begin
                    nneg = 1'b0;
                end
            end else if (pos_ext + 1'b1 >= GRID_LIM) begin
                nneg = 1'b1;
            end
            return {nneg, nneg ? pos - 1'b1 : pos + 1'b1};
        end
    endfunction

    always_comb begin
        in_start_x = i_s_axis_tdata[START_X_LSB +: COORD_IN_W];
        in_start_y = i_s_axis_tdata[START_Y_LSB +: COORD_IN_W];
        in_dir_x   = i_s_axis_tdata[DIR_X_LSB +: DIR_W];
        in_dir_y   = i_s_axis_tdata[DIR_Y_LSB +: DIR_W];
        in_count   = i_s_axis_tdata[COUNT_LSB +: COUNT_W];

        sx_ext     = (CW + COORD_IN_W + 1)'(in_start_x);
        sy_ext     = (CW + COORD_IN_W + 1)'(in_start_y);
        start_x_cl = (sx_ext >= GRID_CMP) ? GRID_MAX : sx_ext[CW-1:0];
        start_y_cl = (sy_ext >= GRID_CMP) ? GRID_MAX : sy_ext[CW-1:0];

        dir_x_sat  = (in_dir_x == {1'b1, {(DIR_W-1){1'b0}}}) ?
                     {1'b1, {(DIR_W-2){1'b0}}, 1'b1} : in_dir_x;
        dir_y_sat  = (in_dir_y == {1'b1, {(DIR_W-1){1'b0}}}) ?
                     {1'b1, {(DIR_W-2){1'b0}}, 1'b1} : in_dir_y;
        abs_x      = dir_x_sat[DIR_W-1] ? (~dir_x_sat + 1'b1) : dir_x_sat;
        abs_y      = dir_y_sat[DIR_W-1] ? (~dir_y_sat + 1'b1) : dir_y_sat;
        count_sat  = (in_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : in_count;

        e2            = $signed({r_err, 1'b0});
        neg_mag_x_ext = -$signed({{(ERR_W-MAG_W+1){1'b0}}, r_mag_x});
        mag_y_ext     = $signed({{(ERR_W-MAG_W+1){1'b0}}, r_mag_y});
        step_y        = e2 > neg_mag_x_ext;
        step_x        = e2 < mag_y_ext;
        y_next        = axis_step(r_cur_y, r_neg_y);
        x_next        = axis_step(r_cur_x, r_neg_x);

        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_neg_x = r_neg_x;
        n_neg_y = r_neg_y;
        n_mag_x = r_mag_x;
        n_mag_y = r_mag_y;
        n_err   = r_err;
        n_left  = r_left;

        if (i_cmd.load) begin
            n_cur_x = start_x_cl;
            n_cur_y = start_y_cl;
            n_neg_x = dir_x_sat[DIR_W-1];
            n_neg_y = dir_y_sat[DIR_W-1];
            n_mag_x = abs_x[MAG_W-1:0];
            n_mag_y = abs_y[MAG_W-1:0];
            n_err   = ERR_W'(abs_y[MAG_W-1:0]) - ERR_W'(abs_x[MAG_W-1:0]);
            n_left  = count_sat;
        end else if (i_cmd.advance) begin
            n_err = r_err - (step_y ? ERR_W'(r_mag_x) : '0)
                          + (step_x ? ERR_W'(r_mag_y) : '0);
            if (step_y) begin
                n_neg_y = y_next[CW];
                n_cur_y = y_next[CW-1:0];
            end
            if (step_x) begin
                n_neg_x = x_next[CW];
                n_cur_x = x_next[CW-1:0];
            end
            n_left = r_left - 1'b1;
        end

        px_ext = (CW + 4)'(r_cur_x);
        py_ext = (CW + 4)'(r_cur_y);
        o_m_axis_tdata = {py_ext[3:0], px_ext[3:0]};

        o_status.count_nonzero = in_count != '0;
        o_status.last          = r_left == COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_neg_x <= 1'b0;
            r_neg_y <= 1'b0;
            r_mag_x <= '0;
            r_mag_y <= '0;
            r_err   <= '0;
            r_left  <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_neg_x <= n_neg_x;
            r_neg_y <= n_neg_y;
            r_mag_x <= n_mag_x;
            r_mag_y <= n_mag_y;
            r_err   <= n_err;
            r_left  <= n_left;
        end
    end

    `ASSERT_CLK(a_cell_on_grid, (r_cur_x <= GRID_MAX) && (r_cur_y <= GRID_MAX), "cell left the grid")
    `ASSERT_CLK(a_advance_counts_down, i_cmd.advance && !i_cmd.load |=> r_left == $past(r_left) - 1'b1, "point counter did not step")

endmodule

`default_nettype wire
